/* rtl/bfd_pkg.sv */
// bfd session table engine: shared types, constants and command/status structs
// no dependencies
`timescale 1ns / 1ps
package bfd_pkg;
  localparam int MaxSessions = 16;
  localparam int SlotW = $clog2(MaxSessions);
  localparam int CntW = $clog2(MaxSessions + 1);

  localparam logic [1:0] REQ_RX    = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_SUB   = 2'd2;
  localparam logic [1:0] REQ_UNSUB = 2'd3;

  localparam logic [1:0] ST_ADMINDOWN = 2'd0;
  localparam logic [1:0] ST_DOWN      = 2'd1;
  localparam logic [1:0] ST_INIT      = 2'd2;
  localparam logic [1:0] ST_UP        = 2'd3;

  localparam logic [4:0] DIAG_NEIGHBOR_DOWN = 5'd3;
  localparam logic [31:0] DISCR_WRAP = 32'h7fffffff;

  localparam logic [1:0] CFG_DES_TX = 2'd0;
  localparam logic [1:0] CFG_REQ_RX = 2'd1;
  localparam logic [1:0] CFG_MULT   = 2'd2;

  typedef struct packed {
    logic       load;      // capture request, run lookup
    logic       rx_apply;  // apply packet update to found/new slot
    logic       subscribe;
    logic       unsubscribe;
    logic       mul;       // deadline multiply stage
    logic       emit_rx;   // emit reply for the target slot
    logic       scan_step; // test and maybe emit one tick slot
  } bfd_cmd_t;

  typedef struct packed {
    logic       done_scan;
    logic [1:0] req;
  } bfd_sts_t;
endpackage

/* rtl/bfd_ctrl.sv */
// bfd session table engine: controller state machine
// depends on bfd_pkg
`timescale 1ns / 1ps
module bfd_ctrl import bfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bfd_sts_t sts,
  output bfd_cmd_t cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_APPL  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_SUB   = 3'd6;
  localparam logic [2:0] S_UNSUB = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        case (sts.req)
          REQ_RX: state_nxt = S_MUL;
          REQ_TICK: state_nxt = S_SCAN;
          REQ_SUB: state_nxt = S_SUB;
          default: state_nxt = S_UNSUB;
        endcase
      end
      S_SUB: begin
        cmd.subscribe = 1'b1;
        state_nxt = S_IDLE;
      end
      S_UNSUB: begin
        cmd.unsubscribe = 1'b1;
        state_nxt = S_IDLE;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_APPL;
      end
      S_APPL: begin
        cmd.rx_apply = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_rx = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.done_scan) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

`ifndef SYNTH
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load outside idle");
  a_apply_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rx_apply |-> $past(cmd.mul)) else $error("apply without multiply");
  a_emit_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_rx |-> $past(cmd.rx_apply)) else $error("emit without apply");
`endif
endmodule

/* rtl/bfd_datapath.sv */
// bfd session table engine: session table, validation, update and packet builder
// depends on bfd_pkg
`timescale 1ns / 1ps
module bfd_datapath import bfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  bfd_cmd_t    cmd,
  output bfd_sts_t    sts,
  input  logic [1:0]  req_type,
  input  logic [31:0] peer_ip,
  input  logic [15:0] peer_port,
  input  logic [9:0]  pkt_length,
  input  logic [7:0]  vers_diag_byte,
  input  logic [7:0]  state_flags_byte,
  input  logic [7:0]  rx_detect_mult,
  input  logic [31:0] rx_my_discr,
  input  logic [31:0] rx_your_discr,
  input  logic [31:0] rx_min_rx_interval,
  input  logic [62:0] now_us,
  input  logic [31:0] des_tx,
  input  logic [31:0] req_rx,
  input  logic [7:0]  mult_cfg,
  output logic        out_valid,
  output logic [31:0] out_ip,
  output logic [15:0] out_port,
  output logic [7:0]  out_vers_diag,
  output logic [7:0]  out_state_flags,
  output logic [7:0]  out_detect_mult,
  output logic [31:0] out_my_discr,
  output logic [31:0] out_your_discr,
  output logic [31:0] out_min_tx,
  output logic [31:0] out_min_rx,
  output logic        last
);
  logic [MaxSessions-1:0] vld_r;
  logic [31:0] ip_m [MaxSessions];
  logic [15:0] port_m [MaxSessions];
  logic [1:0]  lst_m [MaxSessions];
  logic [4:0]  diag_m [MaxSessions];
  logic [31:0] ldis_m [MaxSessions];
  logic [31:0] rdis_m [MaxSessions];
  logic [31:0] rrx_m [MaxSessions];
  logic [3:0]  fl_m [MaxSessions];
  logic [63:0] dl_m [MaxSessions];
  logic [31:0] cnt_r;

  // captured request
  logic [1:0]  rq_r;
  logic [31:0] ip_r, mine_r, yours_r, minrx_r;
  logic [15:0] port_r;
  logic [7:0]  sf_r, mult_r;
  logic        fmt_ok_r;
  logic [62:0] now_r;
  logic [63:0] prod_r;

  // lookup results
  logic              hit_r, hfree_r;
  logic [SlotW-1:0]  hslot_r, fslot_r;
  logic              hit_c, hfree_c;
  logic [SlotW-1:0]  hslot_c, fslot_c;

  // emission tracking
  logic              emit_ok_r;
  logic [SlotW-1:0]  tgt_r;
  logic [SlotW-1:0]  scan_r;
  logic [CntW-1:0]   nout_r;

  always_comb begin
    hit_c = 1'b0; hslot_c = '0; hfree_c = 1'b0; fslot_c = '0;
    for (int i = MaxSessions - 1; i >= 0; i--) begin
      if (vld_r[i] && ip_m[i] == ip_r && port_m[i] == port_r) begin
        hit_c = 1'b1; hslot_c = SlotW'(i);
      end
      if (!vld_r[i]) begin
        hfree_c = 1'b1; fslot_c = SlotW'(i);
      end
    end
  end

  // send permission for a slot, from its discriminators and local state
  function automatic logic send_ok(input logic [31:0] ld, input logic [31:0] rd,
                                   input logic [1:0] ls);
    logic [1:0] st;
    st = (ld != 0) ? ls : ST_DOWN;
    send_ok = !(((rd == 0) || (ld == 0)) && st != ST_DOWN);
  endfunction

  logic [1:0] rst_st;
  logic [31:0] mx;
  assign rst_st = sf_r[7:6];
  assign mx = (minrx_r > des_tx) ? minrx_r : des_tx;

  // slot used by the receive path
  logic             use_new;
  logic [SlotW-1:0] rslot;
  logic             rx_take, rx_newlink;
  assign use_new = !hit_r;
  assign rslot = hit_r ? hslot_r : fslot_r;
  always_comb begin
    rx_take = 1'b0; rx_newlink = 1'b0;
    if (fmt_ok_r && !(yours_r == 0 && !(rst_st == ST_DOWN || rst_st == ST_ADMINDOWN))) begin
      if (hit_r) rx_take = 1'b1;
      else if (hfree_r && (yours_r != 0 || rst_st == ST_DOWN)) begin
        rx_take = 1'b1;
        rx_newlink = (yours_r != 0);
      end
    end
  end

  logic tick_hit;
  logic [SlotW-1:0] ts;
  assign ts = scan_r;
  assign tick_hit = vld_r[ts] && (dl_m[ts] > {1'b0, now_r}) && !fl_m[ts][1]
                    && rdis_m[ts] != 0 && rrx_m[ts] != 0
                    && send_ok(ldis_m[ts], rdis_m[ts], lst_m[ts]);
  logic more_tick;
  always_comb begin
    more_tick = 1'b0;
    for (int j = 0; j < MaxSessions; j++) begin
      if (j > int'(ts) && vld_r[j] && (dl_m[j] > {1'b0, now_r}) && !fl_m[j][1]
          && rdis_m[j] != 0 && rrx_m[j] != 0 && send_ok(ldis_m[j], rdis_m[j], lst_m[j]))
        more_tick = 1'b1;
    end
  end
  assign sts.req = rq_r;
  assign sts.done_scan = (ts == SlotW'(MaxSessions - 1)) ||
                         (tick_hit && nout_r == CntW'(MaxSessions - 1));

  logic [SlotW-1:0] es;
  logic do_out;
  assign es = cmd.scan_step ? ts : tgt_r;
  assign do_out = cmd.scan_step ? (tick_hit && nout_r < CntW'(MaxSessions))
                                 : (cmd.emit_rx && emit_ok_r &&
                                    send_ok(ldis_m[tgt_r], rdis_m[tgt_r], lst_m[tgt_r]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
      out_valid <= 1'b0;
      emit_ok_r <= 1'b0;
      nout_r <= '0;
      scan_r <= '0;
    end else begin
      out_valid <= do_out;
      if (cmd.load) begin
        rq_r <= req_type; ip_r <= peer_ip; port_r <= peer_port;
        sf_r <= state_flags_byte; mult_r <= rx_detect_mult;
        mine_r <= rx_my_discr; yours_r <= rx_your_discr; minrx_r <= rx_min_rx_interval;
        now_r <= now_us;
        fmt_ok_r <= pkt_length == 10'd24 && !state_flags_byte[0] &&
                    vers_diag_byte[7:5] == 3'd1 && !state_flags_byte[2] &&
                    rx_my_discr != 0 && rx_detect_mult != 0;
        emit_ok_r <= 1'b0;
        nout_r <= '0;
        scan_r <= '0;
      end else begin
        hit_r <= hit_c; hslot_r <= hslot_c; hfree_r <= hfree_c; fslot_r <= fslot_c;
      end
      if (cmd.mul) prod_r <= 64'(mult_r) * 64'(mx);
      if (cmd.subscribe && (hit_r || hfree_r)) begin
        vld_r[hit_r ? hslot_r : fslot_r] <= 1'b1;
        ip_m[hit_r ? hslot_r : fslot_r] <= ip_r;
        port_m[hit_r ? hslot_r : fslot_r] <= port_r;
        lst_m[hit_r ? hslot_r : fslot_r] <= ST_DOWN;
        diag_m[hit_r ? hslot_r : fslot_r] <= '0;
        ldis_m[hit_r ? hslot_r : fslot_r] <= '0;
        rdis_m[hit_r ? hslot_r : fslot_r] <= '0;
        rrx_m[hit_r ? hslot_r : fslot_r] <= '0;
        fl_m[hit_r ? hslot_r : fslot_r] <= '0;
        dl_m[hit_r ? hslot_r : fslot_r] <= '0;
      end
      if (cmd.unsubscribe && hit_r) vld_r[hslot_r] <= 1'b0;
      if (cmd.rx_apply && rx_take) begin : apply
        logic [3:0] f;
        logic [1:0] ls;
        logic [31:0] ld, rd;
        logic [4:0] dg;
        logic [31:0] c1;
        f = use_new ? 4'd0 : fl_m[rslot];
        ls = use_new ? ST_DOWN : lst_m[rslot];
        ld = use_new ? 32'd0 : ldis_m[rslot];
        dg = use_new ? 5'd0 : diag_m[rslot];
        rd = mine_r;
        tgt_r <= rslot;
        if (use_new) begin
          vld_r[rslot] <= 1'b1; ip_m[rslot] <= ip_r; port_m[rslot] <= port_r;
          rrx_m[rslot] <= '0; dl_m[rslot] <= '0;
        end
        if (rx_newlink) begin
          lst_m[rslot] <= ST_DOWN; diag_m[rslot] <= '0; fl_m[rslot] <= '0;
          ldis_m[rslot] <= yours_r; rdis_m[rslot] <= mine_r;
          emit_ok_r <= 1'b1;
        end else begin
          if (!f[2]) begin
            f[2] = 1'b1;
            c1 = cnt_r + 32'd1;
            ld = c1;
            cnt_r <= (c1 > DISCR_WRAP) ? 32'd0 : c1;
          end
          f[3] = sf_r[1];
          if (sf_r[4]) f[1] = 1'b1;
          rrx_m[rslot] <= minrx_r;
          dl_m[rslot] <= {1'b0, now_r} + prod_r;
          if (ls != ST_ADMINDOWN) begin
            if (rst_st == ST_ADMINDOWN) begin
              if (ls != ST_DOWN) begin dg = DIAG_NEIGHBOR_DOWN; ls = ST_DOWN; end
            end else if (ls == ST_DOWN) begin
              if (rst_st == ST_DOWN) ls = ST_INIT;
              else if (rst_st == ST_INIT) ls = ST_UP;
            end else if (ls == ST_INIT) begin
              if (rst_st == ST_INIT || rst_st == ST_UP) ls = ST_UP;
              else begin ls = ST_DOWN; rd = '0; end
            end else if (rst_st == ST_DOWN) begin
              dg = DIAG_NEIGHBOR_DOWN; ls = ST_DOWN;
            end
            if (sf_r[5]) f[0] = 1'b1;
            emit_ok_r <= sf_r[5];
          end
          fl_m[rslot] <= f; lst_m[rslot] <= ls; ldis_m[rslot] <= ld;
          rdis_m[rslot] <= rd; diag_m[rslot] <= dg;
        end
      end
      if (cmd.scan_step) begin
        scan_r <= scan_r + SlotW'(1);
        if (do_out) nout_r <= nout_r + CntW'(1);
      end
      if (do_out) begin : build
        logic [1:0] st;
        st = (ldis_m[es] != 0) ? lst_m[es] : ST_DOWN;
        out_ip <= ip_m[es];
        out_port <= port_m[es];
        out_vers_diag <= {3'b001, diag_m[es]};
        out_state_flags <= {st, 1'b0, fl_m[es][0], 1'b1, 3'b000};
        out_detect_mult <= mult_cfg;
        out_my_discr <= ldis_m[es];
        out_your_discr <= rdis_m[es];
        out_min_tx <= des_tx;
        out_min_rx <= req_rx;
        last <= cmd.emit_rx || !more_tick || nout_r == CntW'(MaxSessions - 1);
      end
    end
  end

`ifndef SYNTH
  a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.emit_rx || cmd.scan_step)) else $error("stray output");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DISCR_WRAP) else $error("discriminator counter out of range");
  a_nout: assert property (@(posedge clk) disable iff (!rst_n)
    nout_r <= CntW'(MaxSessions)) else $error("too many tick results");
`endif
endmodule

/* rtl/bfd_session_table_engine_core.sv */
// bfd session table engine top level: config registers, controller and datapath
// depends on bfd_pkg, bfd_ctrl, bfd_datapath
`timescale 1ns / 1ps
// channel | handshake          | payload
// in      | start & !busy      | in_req_type .. in_now_us
// out     | out_valid strobe   | out_ip .. out_min_rx, out_last
// cfg     | cfg_valid & ready  | cfg_index, cfg_data
// receive packet: lookup, multiply, apply, then the reply strobe; sub/unsub: lookup, then the table update
// tick: lookup, then one table slot per cycle through the scan step
// synchronous active-low reset clears the table valid bits and counter
// the receiver cannot stall: each result strobes for one cycle
module bfd_session_table_engine_core import bfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_peer_ip,
  input  logic [15:0] in_peer_port,
  input  logic [9:0]  in_pkt_length,
  input  logic [7:0]  in_vers_diag_byte,
  input  logic [7:0]  in_state_flags_byte,
  input  logic [7:0]  in_rx_detect_mult,
  input  logic [31:0] in_rx_my_discr,
  input  logic [31:0] in_rx_your_discr,
  input  logic [31:0] in_rx_min_rx_interval,
  input  logic [62:0] in_now_us,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [31:0] out_ip,
  output logic [15:0] out_port,
  output logic [7:0]  out_vers_diag,
  output logic [7:0]  out_state_flags,
  output logic [7:0]  out_detect_mult,
  output logic [31:0] out_my_discr,
  output logic [31:0] out_your_discr,
  output logic [31:0] out_min_tx,
  output logic [31:0] out_min_rx,
  output logic        out_last
);
  logic [31:0] des_tx_r, req_rx_r;
  logic [7:0]  mult_r;
  bfd_cmd_t cmd;
  bfd_sts_t sts;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      des_tx_r <= 32'd1000000;
      req_rx_r <= 32'd1000000;
      mult_r <= 8'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DES_TX: des_tx_r <= cfg_data;
        CFG_REQ_RX: req_rx_r <= cfg_data;
        CFG_MULT: mult_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  bfd_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .sts, .cmd);

  bfd_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .req_type(in_req_type), .peer_ip(in_peer_ip), .peer_port(in_peer_port),
    .pkt_length(in_pkt_length), .vers_diag_byte(in_vers_diag_byte),
    .state_flags_byte(in_state_flags_byte), .rx_detect_mult(in_rx_detect_mult),
    .rx_my_discr(in_rx_my_discr), .rx_your_discr(in_rx_your_discr),
    .rx_min_rx_interval(in_rx_min_rx_interval), .now_us(in_now_us),
    .des_tx(des_tx_r), .req_rx(req_rx_r), .mult_cfg(mult_r),
    .out_valid, .out_ip, .out_port, .out_vers_diag, .out_state_flags,
    .out_detect_mult, .out_my_discr, .out_your_discr, .out_min_tx, .out_min_rx,
    .last(out_last)
  );
endmodule

/* sim/bfd_session_table_engine_core_test.sv */
// testbench for bfd_session_table_engine_core: session table, receive state machine and tick scan
// depends on bfd_pkg and the rtl top level; self-checking against an in-bench session predictor
`timescale 1ns / 1ps
module bfd_session_table_engine_core_test;
  import bfd_pkg::*;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] ip;
    logic [15:0] port;
    logic [9:0]  len;
    logic [7:0]  vd;
    logic [7:0]  sf;
    logic [7:0]  mult;
    logic [31:0] mine;
    logic [31:0] yours;
    logic [31:0] minrx;
    logic [62:0] now;
  } bfd_req_t;

  typedef struct {
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  vd;
    logic [7:0]  sf;
    logic [7:0]  dm;
    logic [31:0] my;
    logic [31:0] your;
    logic [31:0] mintx;
    logic [31:0] minrx;
    logic        last;
  } bfd_tx_t;

  localparam int NumPeers = 20;
  localparam logic [3:0] FL_FINAL = 4'd1;
  localparam logic [3:0] FL_TERM = 4'd2;
  localparam logic [3:0] FL_LINKED = 4'd4;
  localparam logic [3:0] FL_DEMAND = 4'd8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type = '0;
  logic [31:0] in_peer_ip = '0;
  logic [15:0] in_peer_port = '0;
  logic [9:0]  in_pkt_length = '0;
  logic [7:0]  in_vers_diag_byte = '0;
  logic [7:0]  in_state_flags_byte = '0;
  logic [7:0]  in_rx_detect_mult = '0;
  logic [31:0] in_rx_my_discr = '0;
  logic [31:0] in_rx_your_discr = '0;
  logic [31:0] in_rx_min_rx_interval = '0;
  logic [62:0] in_now_us = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        out_valid;
  logic [31:0] out_ip;
  logic [15:0] out_port;
  logic [7:0]  out_vers_diag;
  logic [7:0]  out_state_flags;
  logic [7:0]  out_detect_mult;
  logic [31:0] out_my_discr;
  logic [31:0] out_your_discr;
  logic [31:0] out_min_tx;
  logic [31:0] out_min_rx;
  logic        out_last;

  bfd_session_table_engine_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] des_tx = 32'd1000000;
  logic [31:0] req_rx = 32'd1000000;
  logic [7:0]  loc_mult = 8'd3;
  logic        tbl_valid [MaxSessions];
  logic [31:0] tbl_ip [MaxSessions];
  logic [15:0] tbl_port [MaxSessions];
  logic [1:0]  tbl_lstate [MaxSessions];
  logic [1:0]  tbl_rstate [MaxSessions];
  logic [4:0]  tbl_diag [MaxSessions];
  logic [31:0] tbl_ldisc [MaxSessions];
  logic [31:0] tbl_rdisc [MaxSessions];
  logic [31:0] tbl_rrx [MaxSessions];
  logic [3:0]  tbl_flags [MaxSessions];
  logic [63:0] tbl_deadline [MaxSessions];
  logic [31:0] disc_counter = '0;

  bfd_req_t pending_q[$];
  bfd_tx_t  packet_q[$];
  bfd_tx_t  burst_q[$];
  bfd_req_t cur;
  int gap = 0;
  bit calm = 0;
  int errors = 0;
  int n_items = 0;
  int n_packets = 0;

  logic [31:0] peer_ip [NumPeers];
  logic [15:0] peer_port [NumPeers];
  logic [62:0] clock_us = 63'd1000;

  function automatic int find_session(logic [31:0] ip, logic [15:0] port);
    for (int i = 0; i < MaxSessions; i++)
      if (tbl_valid[i] && tbl_ip[i] == ip && tbl_port[i] == port) return i;
    return -1;
  endfunction

  function automatic int install_session(logic [31:0] ip, logic [15:0] port);
    int s;
    s = find_session(ip, port);
    if (s < 0)
      for (int i = 0; i < MaxSessions; i++)
        if (!tbl_valid[i]) begin
          s = i;
          break;
        end
    if (s < 0) return -1;
    tbl_valid[s] = 1'b1;
    tbl_ip[s] = ip;
    tbl_port[s] = port;
    tbl_lstate[s] = ST_DOWN;
    tbl_rstate[s] = ST_DOWN;
    tbl_diag[s] = '0;
    tbl_ldisc[s] = '0;
    tbl_rdisc[s] = '0;
    tbl_rrx[s] = '0;
    tbl_flags[s] = '0;
    tbl_deadline[s] = '0;
    return s;
  endfunction

  function automatic void send_control(int s);
    bfd_tx_t t;
    logic [1:0] st;
    if (burst_q.size() >= 16) return;
    st = (tbl_ldisc[s] != 0) ? tbl_lstate[s] : ST_DOWN;
    if ((tbl_rdisc[s] == 0 || tbl_ldisc[s] == 0) && st != ST_DOWN) return;
    t.ip = tbl_ip[s];
    t.port = tbl_port[s];
    t.vd = {3'd1, tbl_diag[s]};
    t.sf = {st, 1'b0, (tbl_flags[s] & FL_FINAL) != 0, 1'b1, 3'b000};
    t.dm = loc_mult;
    t.my = tbl_ldisc[s];
    t.your = tbl_rdisc[s];
    t.mintx = des_tx;
    t.minrx = req_rx;
    t.last = 1'b0;
    burst_q.push_back(t);
  endfunction

  function automatic void receive_packet(bfd_req_t r);
    logic [1:0] rst;
    logic [31:0] mx;
    int s;
    rst = r.sf[7:6];
    if (r.len != 10'd24 || r.sf[0] || r.vd[7:5] != 3'd1 || r.sf[2]) return;
    if (r.mine == 0 || r.mult == 0) return;
    if (r.yours == 0 && !(rst == ST_DOWN || rst == ST_ADMINDOWN)) return;
    s = find_session(r.ip, r.port);
    if (s < 0 && r.yours != 0) begin
      s = install_session(r.ip, r.port);
      if (s < 0) return;
      tbl_rdisc[s] = r.mine;
      tbl_ldisc[s] = r.yours;
      tbl_lstate[s] = ST_DOWN;
      send_control(s);
      return;
    end
    if (s < 0) begin
      if (rst != ST_DOWN) return;
      s = install_session(r.ip, r.port);
      if (s < 0) return;
    end
    if ((tbl_flags[s] & FL_LINKED) == 0) begin
      tbl_flags[s] |= FL_LINKED;
      disc_counter++;
      tbl_ldisc[s] = disc_counter;
      if (disc_counter > DISCR_WRAP) disc_counter = '0;
    end
    tbl_rstate[s] = rst;
    if (r.sf[1]) tbl_flags[s] |= FL_DEMAND;
    else tbl_flags[s] &= ~FL_DEMAND;
    tbl_rdisc[s] = r.mine;
    tbl_rrx[s] = r.minrx;
    if (r.sf[4]) tbl_flags[s] |= FL_TERM;
    mx = (r.minrx > des_tx) ? r.minrx : des_tx;
    tbl_deadline[s] = {1'b0, r.now} + 64'(r.mult) * 64'(mx);
    if (tbl_lstate[s] == ST_ADMINDOWN) return;
    if (rst == ST_ADMINDOWN) begin
      if (tbl_lstate[s] != ST_DOWN) begin
        tbl_diag[s] = DIAG_NEIGHBOR_DOWN;
        tbl_lstate[s] = ST_DOWN;
      end
    end else if (tbl_lstate[s] == ST_DOWN) begin
      if (rst == ST_DOWN) tbl_lstate[s] = ST_INIT;
      else if (rst == ST_INIT) tbl_lstate[s] = ST_UP;
    end else if (tbl_lstate[s] == ST_INIT) begin
      if (rst == ST_INIT || rst == ST_UP) tbl_lstate[s] = ST_UP;
      else begin
        tbl_lstate[s] = ST_DOWN;
        tbl_rdisc[s] = '0;
      end
    end else if (rst == ST_DOWN) begin
      tbl_diag[s] = DIAG_NEIGHBOR_DOWN;
      tbl_lstate[s] = ST_DOWN;
    end
    if (r.sf[5]) begin
      tbl_flags[s] |= FL_FINAL;
      send_control(s);
    end
  endfunction

  function automatic void predict_packets(bfd_req_t r);
    int s;
    burst_q.delete();
    case (r.req)
      REQ_RX: receive_packet(r);
      REQ_TICK: begin
        for (int i = 0; i < MaxSessions; i++) begin
          if (!tbl_valid[i] || !(tbl_deadline[i] > {1'b0, r.now})) continue;
          if ((tbl_flags[i] & FL_TERM) != 0 || tbl_rdisc[i] == 0 || tbl_rrx[i] == 0) continue;
          send_control(i);
        end
      end
      REQ_SUB: s = install_session(r.ip, r.port);
      default: begin
        s = find_session(r.ip, r.port);
        if (s >= 0) tbl_valid[s] = 1'b0;
      end
    endcase
    if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
    foreach (burst_q[k]) packet_q.push_back(burst_q[k]);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      predict_packets(cur);
      n_items++;
    end
    if (start && busy) begin
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (rst_n && pending_q.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
      gap <= $urandom_range(1, 4);
      start <= 1'b0;
    end else if (rst_n && pending_q.size() > 0) begin
      cur = pending_q.pop_front();
      in_req_type <= cur.req;
      in_peer_ip <= cur.ip;
      in_peer_port <= cur.port;
      in_pkt_length <= cur.len;
      in_vers_diag_byte <= cur.vd;
      in_state_flags_byte <= cur.sf;
      in_rx_detect_mult <= cur.mult;
      in_rx_my_discr <= cur.mine;
      in_rx_your_discr <= cur.yours;
      in_rx_min_rx_interval <= cur.minrx;
      in_now_us <= cur.now;
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch expected %0h actual %0h", $time, name, e, a);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    bfd_tx_t e;
    if (rst_n && out_valid) begin
      n_packets++;
      if (packet_q.size() == 0) begin
        $display("%0t: unexpected packet to %0h:%0h", $time, out_ip, out_port);
        errors++;
      end else begin
        e = packet_q.pop_front();
        check_field("out_ip", e.ip, out_ip);
        check_field("out_port", e.port, out_port);
        check_field("out_vers_diag", e.vd, out_vers_diag);
        check_field("out_state_flags", e.sf, out_state_flags);
        check_field("out_detect_mult", e.dm, out_detect_mult);
        check_field("out_my_discr", e.my, out_my_discr);
        check_field("out_your_discr", e.your, out_your_discr);
        check_field("out_min_tx", e.mintx, out_min_tx);
        check_field("out_min_rx", e.minrx, out_min_rx);
        check_field("out_last", e.last, out_last);
      end
    end
  end

  function automatic bfd_req_t control_pkt(int p, logic [1:0] st, bit poll, bit fin,
                                           logic [31:0] yours);
    bfd_req_t r;
    r.req = REQ_RX;
    r.ip = peer_ip[p];
    r.port = peer_port[p];
    r.len = 10'd24;
    r.vd = {3'd1, 5'($urandom)};
    r.sf = {st, poll, fin, 1'($urandom), 1'b0, 1'($urandom), 1'b0};
    r.mult = 8'($urandom_range(1, 255));
    r.mine = $urandom_range(1, 32'hffffffff);
    r.yours = yours;
    r.minrx = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 2000000);
    r.now = clock_us;
    return r;
  endfunction

  function automatic bfd_req_t keyed_req(logic [1:0] op, int p);
    bfd_req_t r;
    r = control_pkt(p, ST_DOWN, 0, 0, 0);
    r.req = op;
    return r;
  endfunction

  function automatic bfd_req_t noise_req();
    bfd_req_t r;
    r.req = 2'($urandom);
    r.ip = $urandom;
    r.port = 16'($urandom);
    r.len = 10'($urandom);
    r.vd = 8'($urandom);
    r.sf = 8'($urandom);
    r.mult = 8'($urandom);
    r.mine = $urandom;
    r.yours = $urandom;
    r.minrx = $urandom;
    r.now = 63'({$urandom, $urandom});
    return r;
  endfunction

  function automatic bfd_req_t random_req();
    int pick;
    int p;
    pick = $urandom_range(0, 99);
    p = $urandom_range(0, NumPeers - 1);
    clock_us += 63'($urandom_range(0, 3000));
    if ($urandom_range(0, 40) == 0) clock_us += 63'($urandom_range(1, 32'hffffffff));
    if (pick < 72)
      return control_pkt(p, 2'($urandom), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 9) == 0,
                         ($urandom_range(0, 3) == 0) ? $urandom : 32'd0);
    if (pick < 84) return keyed_req(REQ_TICK, p);
    if (pick < 91) return keyed_req(REQ_SUB, p);
    if (pick < 96) return keyed_req(REQ_UNSUB, p);
    return noise_req();
  endfunction

  task automatic wait_quiet();
    wait (pending_q.size() == 0 && !start && gap == 0 && packet_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DES_TX: des_tx = val;
      CFG_REQ_RX: req_rx = val;
      default: loc_mult = val[7:0];
    endcase
  endtask

  initial begin
    bfd_req_t r;
    for (int i = 0; i < MaxSessions; i++) tbl_valid[i] = 1'b0;
    for (int k = 0; k < NumPeers; k++) begin
      peer_ip[k] = (k == 0) ? 32'h0 : (k == 1) ? 32'hffffffff : $urandom;
      peer_port[k] = (k == 0) ? 16'h0 : (k == 1) ? 16'hffff : 16'($urandom);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed transactions
    pending_q.push_back(keyed_req(REQ_SUB, 0));
    pending_q.push_back(control_pkt(0, ST_DOWN, 1, 0, 0));
    pending_q.push_back(control_pkt(0, ST_INIT, 1, 0, 0));
    pending_q.push_back(control_pkt(0, ST_UP, 1, 0, 0));
    pending_q.push_back(keyed_req(REQ_TICK, 0));
    r = control_pkt(1, ST_DOWN, 1, 0, 0); r.len = 10'd23; pending_q.push_back(r);
    r = control_pkt(1, ST_DOWN, 1, 0, 0); r.len = 10'd1023; pending_q.push_back(r);
    r = control_pkt(1, ST_DOWN, 1, 0, 0); r.vd = 8'hff; pending_q.push_back(r);
    r = control_pkt(1, ST_DOWN, 1, 0, 0); r.sf[0] = 1'b1; pending_q.push_back(r);
    r = control_pkt(1, ST_DOWN, 1, 0, 0); r.sf[2] = 1'b1; pending_q.push_back(r);
    r = control_pkt(1, ST_DOWN, 1, 0, 0); r.mine = '0; pending_q.push_back(r);
    r = control_pkt(1, ST_DOWN, 1, 0, 0); r.mult = '0; pending_q.push_back(r);
    pending_q.push_back(control_pkt(1, ST_UP, 1, 0, 0));
    pending_q.push_back(control_pkt(2, ST_INIT, 0, 0, 32'hffffffff));
    pending_q.push_back(control_pkt(2, ST_DOWN, 1, 0, 0));
    pending_q.push_back(control_pkt(0, ST_ADMINDOWN, 1, 0, 0));
    pending_q.push_back(control_pkt(0, ST_DOWN, 1, 1, 0));
    pending_q.push_back(keyed_req(REQ_UNSUB, 5));
    r = control_pkt(3, ST_DOWN, 1, 0, 0); r.minrx = 32'hffffffff; r.mult = 8'hff;
    pending_q.push_back(r);
    r = keyed_req(REQ_TICK, 0); r.now = '1; pending_q.push_back(r);
    pending_q.push_back(keyed_req(REQ_TICK, 0));
    pending_q.push_back(keyed_req(REQ_UNSUB, 0));
    pending_q.push_back(keyed_req(REQ_TICK, 0));
    wait_quiet();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_DES_TX, 32'd1);
          write_reg(CFG_REQ_RX, 32'hffffffff);
          write_reg(CFG_MULT, 32'd255);
        end
        1: begin
          write_reg(CFG_DES_TX, 32'hffffffff);
          write_reg(CFG_REQ_RX, 32'd1);
          write_reg(CFG_MULT, 32'd1);
        end
        default: begin
          write_reg(CFG_DES_TX, $urandom_range(1, 5000));
          write_reg(CFG_REQ_RX, $urandom);
          write_reg(CFG_MULT, $urandom_range(1, 255));
          calm = 1;
        end
      endcase
      for (int k = 0; k < 130; k++) pending_q.push_back(random_req());
      wait_quiet();
    end

    $display("run covered %0d transactions and %0d transmitted packets", n_items, n_packets);
    $display("four register settings including interval and multiplier extremes");
    if (errors == 0) $display("bfd_session_table_engine_core verification clean");
    else $display("bfd_session_table_engine_core verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("bfd_session_table_engine_core verification failed");
    $finish;
  end
endmodule
